FILE: rtl/core/constant_modular_multiplier_macros.svh
// Assertion macros used by the constant modular multiplier top level.
// Plain text macros only; no package or module dependencies.
`ifndef CONSTANT_MODULAR_MULTIPLIER_MACROS_SVH
`define CONSTANT_MODULAR_MULTIPLIER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CMM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cmm assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define CMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cmm assertion failed: next-cycle implication");

`endif

FILE: rtl/core/cmm_pkg.sv
// Package for the constant modular multiplier: default width, register
// indexes and register reset values. No dependencies.
`default_nettype none

package cmm_pkg;

  localparam int DEFAULT_WIDTH = 32;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 1'd1;

  // Reset values, truncated to the configured width where they are used
  localparam logic [63:0] RST_MULTIPLIER = 64'd1;
  localparam logic [63:0] RST_MODULUS    = 64'h0000_0000_FFFF_FFFF;

endpackage

`default_nettype wire

FILE: rtl/core/constant_modular_multiplier.sv
// Constant modular multiplier: for each operand y, returns x*y mod N, where
// x (multiplier) and N (modulus) are configuration registers. The multiplier
// bits are scanned from the top down, one double-mod stage and one add-mod
// stage per lower bit, after an entry stage that loads y or 0 from the top
// bit. The pipe holds 2*WIDTH-1 register stages, the first loaded at the
// accepting edge itself, the last feeding out_valid and out_product.
// Throughput is one item per cycle while out_ready stays high.
// Each stage holds at most one WIDTH+1-bit add and one compare. The whole
// pipeline advances as one:
// when a result waits at the output with out_ready low, every stage holds and
// in_ready drops, so nothing is lost or repeated. The stages read the
// configuration registers directly, so write x and N only while the pipeline
// holds no item. Operands not below N follow the same fixed step rule and may
// come out not fully reduced; N of zero yields x*y mod 2^WIDTH.
// Depends on cmm_pkg, cmm_dbl_stage, cmm_add_stage and the macro header.
`default_nettype none

`include "constant_modular_multiplier_macros.svh"

module constant_modular_multiplier #(
  parameter int WIDTH = cmm_pkg::DEFAULT_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration write port
  input  wire logic                         cfg_we,
  input  wire logic [cmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WIDTH-1:0]             cfg_wdata,
  // operand channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [WIDTH-1:0]             in_operand,
  // product channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [WIDTH-1:0]             out_product
);

  // Entry stage plus a double and an add stage for each lower bit
  localparam int NSTG = 2 * WIDTH - 1;

  logic [WIDTH-1:0] multiplier_r;
  logic [WIDTH-1:0] modulus_r;

  logic             vld0_r;
  logic [WIDTH-1:0] acc0_r;
  logic [WIDTH-1:0] y0_r;
  logic [WIDTH-1:0] acc0_nxt;

  logic             advance;
  logic             in_fire;

  logic [NSTG-1:0]  stg_vld;
  logic [WIDTH-1:0] stg_acc [NSTG];
  logic [WIDTH-1:0] stg_y   [NSTG];

  // Configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      multiplier_r <= WIDTH'(cmm_pkg::RST_MULTIPLIER);
      modulus_r    <= WIDTH'(cmm_pkg::RST_MODULUS);
    end else if (cfg_we) begin
      case (cfg_index)
        cmm_pkg::REG_MULTIPLIER: multiplier_r <= cfg_wdata;
        cmm_pkg::REG_MODULUS:    modulus_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless a finished result is stalled
  assign advance  = out_ready || !out_valid;
  assign in_ready = advance;
  assign in_fire  = in_valid && in_ready;

  // Entry stage: start from y when the top multiplier bit is set
  assign acc0_nxt = multiplier_r[WIDTH-1] ? in_operand : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (advance) begin
      vld0_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      acc0_r <= acc0_nxt;
      y0_r   <= in_operand;
    end
  end

  assign stg_vld[0] = vld0_r;
  assign stg_acc[0] = acc0_r;
  assign stg_y[0]   = y0_r;

  // One double/add pair per multiplier bit, from bit WIDTH-2 down to bit 0
  for (genvar k = 0; k < WIDTH - 1; k++) begin : g_bit
    cmm_dbl_stage #(
      .WIDTH(WIDTH)
    ) u_dbl (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (advance),
      .modulus(modulus_r),
      .vld_i  (stg_vld[2*k]),
      .acc_i  (stg_acc[2*k]),
      .y_i    (stg_y[2*k]),
      .vld_o  (stg_vld[2*k+1]),
      .acc_o  (stg_acc[2*k+1]),
      .y_o    (stg_y[2*k+1])
    );

    cmm_add_stage #(
      .WIDTH(WIDTH)
    ) u_add (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (advance),
      .modulus(modulus_r),
      .bit_set(multiplier_r[WIDTH-2-k]),
      .vld_i  (stg_vld[2*k+1]),
      .acc_i  (stg_acc[2*k+1]),
      .y_i    (stg_y[2*k+1]),
      .vld_o  (stg_vld[2*k+2]),
      .acc_o  (stg_acc[2*k+2]),
      .y_o    (stg_y[2*k+2])
    );
  end

  // Last add stage doubles as the output register
  assign out_valid   = stg_vld[NSTG-1];
  assign out_product = stg_acc[NSTG-1];

  // A stall freezes every valid bit in the pipe
  `CMM_ASSERT_NEXT(a_stall_holds, clk, rst_n, !advance, $stable(stg_vld))
  // An accepted item lands in the entry stage
  `CMM_ASSERT_NEXT(a_entry_load, clk, rst_n, in_fire, stg_vld[0])
  // An item in the entry stage moves on when the pipe advances
  `CMM_ASSERT_NEXT(a_entry_moves, clk, rst_n, stg_vld[0] && advance, stg_vld[1])
  // The output can only stall on a real result
  `CMM_ASSERT_IMPLY(a_stall_valid, clk, rst_n, !in_ready, out_valid && !out_ready)

endmodule

`default_nettype wire

FILE: rtl/core/cmm_dbl_stage.sv
// One doubling stage of the multiplier pipeline: acc <- 2*acc mod N.
// Uses cmm_pkg for the default width.
`default_nettype none

module cmm_dbl_stage #(
  parameter int WIDTH = cmm_pkg::DEFAULT_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] modulus,
  input  wire logic             vld_i,
  input  wire logic [WIDTH-1:0] acc_i,
  input  wire logic [WIDTH-1:0] y_i,
  output logic                  vld_o,
  output logic      [WIDTH-1:0] acc_o,
  output logic      [WIDTH-1:0] y_o
);

  logic             vld_r;
  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] y_r;
  logic [WIDTH-1:0] acc_nxt;
  logic [WIDTH:0]   dbl;
  logic [WIDTH+1:0] diff;

  // Form 2*acc in WIDTH+1 bits; subtract N once when no borrow results
  always_comb begin
    dbl     = {acc_i, 1'b0};
    diff    = {1'b0, dbl} - {2'b00, modulus};
    acc_nxt = diff[WIDTH+1] ? dbl[WIDTH-1:0] : diff[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      y_r   <= y_i;
    end
  end

  assign vld_o = vld_r;
  assign acc_o = acc_r;
  assign y_o   = y_r;

endmodule

`default_nettype wire

FILE: rtl/core/cmm_add_stage.sv
// One conditional add stage of the multiplier pipeline: acc <- acc+y mod N
// when the scanned multiplier bit is set. Uses cmm_pkg for the default width.
`default_nettype none

module cmm_add_stage #(
  parameter int WIDTH = cmm_pkg::DEFAULT_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] modulus,
  input  wire logic             bit_set,
  input  wire logic             vld_i,
  input  wire logic [WIDTH-1:0] acc_i,
  input  wire logic [WIDTH-1:0] y_i,
  output logic                  vld_o,
  output logic      [WIDTH-1:0] acc_o,
  output logic      [WIDTH-1:0] y_o
);

  logic             vld_r;
  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] y_r;
  logic [WIDTH-1:0] acc_nxt;
  logic [WIDTH:0]   sum;
  logic [WIDTH+1:0] diff;

  // Sum in WIDTH+1 bits; subtract N once when no borrow results
  always_comb begin
    sum  = {1'b0, acc_i} + {1'b0, y_i};
    diff = {1'b0, sum} - {2'b00, modulus};
    if (bit_set) begin
      acc_nxt = diff[WIDTH+1] ? sum[WIDTH-1:0] : diff[WIDTH-1:0];
    end else begin
      acc_nxt = acc_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      y_r   <= y_i;
    end
  end

  assign vld_o = vld_r;
  assign acc_o = acc_r;
  assign y_o   = y_r;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for constant_modular_multiplier: directed vectors, then
// random operands under several multiplier/modulus settings and idle patterns.
// Depends on cmm_pkg and the constant_modular_multiplier RTL.

module tb_top;

  localparam int W            = 32;
  localparam int LATENCY      = 2 * W - 2;
  localparam int QUIET_LIMIT  = 2000;   // cycles with no handshake at all
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int SEGMENTS     = 12;
  localparam int SEG_ITEMS    = 110;
  localparam logic [W-1:0] RESET_MULT = cmm_pkg::RST_MULTIPLIER[W-1:0];
  localparam logic [W-1:0] RESET_MOD  = cmm_pkg::RST_MODULUS[W-1:0];

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [cmm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [W-1:0]                  cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  logic [W-1:0]                  in_operand;
  logic                          out_valid;
  logic                          out_ready;
  logic [W-1:0]                  out_product;

  // Expected value riding along with the operand; used when it is typed in by hand.
  logic                 stim_known;
  logic [W-1:0]         stim_product;

  logic [W-1:0] cur_multiplier = RESET_MULT;
  logic [W-1:0] cur_modulus    = RESET_MOD;
  logic [W-1:0] pending_products[$];
  int           fail_count  = 0;
  int           quiet_cycles = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           hold_req = 1'b0;

  // One directed row: configuration, operand and, where obvious, the product.
  typedef struct packed {
    logic [W-1:0] mult;
    logic [W-1:0] modulus;
    logic [W-1:0] operand;
    logic         known;
    logic [W-1:0] product;
  } vector_t;

  localparam int N_VECS = 22;
  vector_t directed_vecs [N_VECS] = '{
    // reset settings: x = 1, N = all ones
    '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 32'h1234_5678},
    '{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
    '{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    // zero multiplier
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b1, 32'h0000_0000},
    // all-ones multiplier, congruent to zero
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 1'b0, 32'h0000_0000},
    // small modulus, operand in and far out of range
    '{32'h0000_0005, 32'h0000_0007, 32'h0000_0003, 1'b1, 32'h0000_0001},
    '{32'h0000_0005, 32'h0000_0007, 32'h0000_0006, 1'b0, 32'h0000_0000},
    '{32'h0000_0005, 32'h0000_0007, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    // only the top multiplier bit set
    '{32'h8000_0000, 32'hFFFF_FFFB, 32'h0000_0001, 1'b1, 32'h8000_0000},
    '{32'h8000_0000, 32'hFFFF_FFFB, 32'hFFFF_FFFA, 1'b0, 32'h0000_0000},
    // operand at and above the modulus
    '{32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000},
    '{32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    // smallest modulus
    '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    // modulus zero wraps at 2^32, then a small power-of-two modulus
    '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
    '{32'h0000_0003, 32'h0000_0000, 32'h0000_0005, 1'b1, 32'h0000_000F},
    '{32'hDEAD_BEEF, 32'h0000_0000, 32'h1234_5678, 1'b0, 32'h0000_0000},
    '{32'h1234_5678, 32'h0000_1000, 32'h0000_0999, 1'b0, 32'h0000_0000}
  };

  constant_modular_multiplier #(.WIDTH(W)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_operand (in_operand),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_product(out_product)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Double-and-add over the multiplier bits, top bit first. Each step works in
  // W+1 bits, takes N off once when the value reaches N, and keeps W bits.
  function automatic logic [W-1:0] modmul_product(input logic [W-1:0] x,
                                                  input logic [W-1:0] y,
                                                  input logic [W-1:0] n);
    logic [W:0] acc;
    acc = x[W-1] ? {1'b0, y} : '0;
    for (int i = W - 2; i >= 0; i--) begin
      acc = {acc[W-1:0], 1'b0};
      if (acc >= {1'b0, n}) acc = acc - {1'b0, n};
      acc[W] = 1'b0;
      if (x[i]) begin
        acc = acc + {1'b0, y};
        if (acc >= {1'b0, n}) acc = acc - {1'b0, n};
        acc[W] = 1'b0;
      end
    end
    return acc[W-1:0];
  endfunction

  // Track register writes, queue a product for every accepted operand and
  // check every accepted product against the oldest one queued.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          cmm_pkg::REG_MULTIPLIER: cur_multiplier = cfg_wdata;
          cmm_pkg::REG_MODULUS:    cur_modulus    = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_products = {pending_products,
                            stim_known ? stim_product
                                       : modmul_product(cur_multiplier, in_operand,
                                                        cur_modulus)};
      if (out_valid && out_ready) begin
        if (pending_products.size() == 0) begin
          $error("product: unexpected item, actual %h", out_product);
          fail_count++;
        end else begin
          if (out_product !== pending_products[0]) begin
            $error("product: expected %h, actual %h", pending_products[0], out_product);
            fail_count++;
          end
          void'(pending_products.pop_front());
        end
      end
    end
  end

  // Watchdog: end the run when no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else if (quiet_cycles == QUIET_LIMIT) begin
      $display("constant_modular_multiplier regression: fail");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Receiver: random stalls at the current rate; on request, hold off for a
  // long stretch so the pipeline fills and pushes back on the sender.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one operand, idling first at the sender's rate, and return at the
  // edge that accepts it.
  task automatic send_item(input logic [W-1:0] operand, input logic known,
                           input logic [W-1:0] product);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_operand   <= operand;
    stim_known   <= known;
    stim_product <= product;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every queued product has come out. Wait for
  // the next edge first so the item accepted at the last edge is already queued.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_products.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges; the pipeline must be empty.
  task automatic set_config(input logic [W-1:0] mult, input logic [W-1:0] modulus);
    cfg_we    <= 1'b1;
    cfg_index <= cmm_pkg::REG_MULTIPLIER;
    cfg_wdata <= mult;
    @(posedge clk);
    cfg_index <= cmm_pkg::REG_MODULUS;
    cfg_wdata <= modulus;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly operands below the modulus, with zero, N-1 and unreduced values mixed in.
  function automatic logic [W-1:0] pick_operand(input logic [W-1:0] n);
    int r;
    r = $urandom_range(99);
    if (r < 5)  return '0;
    if (r < 10) return (n == 0) ? '1 : n - 1;
    if (r < 25) return $urandom;
    return (n == 0) ? $urandom : $urandom % n;
  endfunction

  initial begin
    logic [W-1:0] last_mult;
    logic [W-1:0] last_mod;
    logic [W-1:0] mult;
    logic [W-1:0] modulus;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = cmm_pkg::REG_MULTIPLIER;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_operand   = '0;
    stim_known   = 1'b0;
    stim_product = '0;
    last_mult    = RESET_MULT;
    last_mod     = RESET_MOD;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: reconfigure only when the row's settings change.
    send_idle_pct = 21;
    recv_idle_pct = 72;
    for (int v = 0; v < N_VECS; v++) begin
      if (directed_vecs[v].mult !== last_mult || directed_vecs[v].modulus !== last_mod) begin
        drain();
        set_config(directed_vecs[v].mult, directed_vecs[v].modulus);
        last_mult = directed_vecs[v].mult;
        last_mod  = directed_vecs[v].modulus;
      end
      send_item(directed_vecs[v].operand, directed_vecs[v].known, directed_vecs[v].product);
    end

    // Random segments: new settings each time, idle pattern by thirds.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin mult = $urandom;     modulus = '1;                        end
        1: begin mult = '1;           modulus = $urandom | 32'h8000_0000;  end
        2: begin mult = '0;           modulus = $urandom;                  end
        3: begin mult = $urandom;     modulus = 32'd1;                     end
        4: begin mult = $urandom;     modulus = '0;                        end
        5: begin mult = 32'd1;        modulus = 32'h8000_0000;             end
        default: begin
          mult    = $urandom >> $urandom_range(0, 24);
          modulus = $urandom >> $urandom_range(0, 28);
        end
      endcase
      if (seg < 4) begin
        send_idle_pct = 21;
        recv_idle_pct = 72;
      end else if (seg < 8) begin
        send_idle_pct = 72;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      set_config(mult, modulus);
      // Hold the receiver off while the sender keeps going.
      if (seg == 1 || seg == 9) hold_req = 1'b1;
      for (int k = 0; k < SEG_ITEMS; k++)
        send_item(pick_operand(modulus), 1'b0, '0);
    end

    drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (fail_count == 0)
      $display("constant_modular_multiplier regression: pass");
    else
      $display("constant_modular_multiplier regression: fail");
    $finish;
  end

endmodule

FILE: constant_modular_multiplier.f
+incdir+rtl/core
rtl/core/cmm_pkg.sv
rtl/core/cmm_dbl_stage.sv
rtl/core/cmm_add_stage.sv
rtl/core/constant_modular_multiplier.sv
test/tb_top.sv
